// ===== design/psd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the point to segment distance pipeline.
// No dependencies.
package psd_pkg;

    // Projection parameter in Q0.16, one extra bit so that the segment end fits.
    localparam int QBITS   = 16;
    localparam int POS_BITS = QBITS + 1;
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1) << QBITS;

    // One quotient bit beyond the parameter's precision, for rounding.
    localparam int NDIV = QBITS + 1;

    // How the projection parameter is settled for an item.
    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_ONE  = 2'd1;
    localparam logic [1:0] MODE_DIV  = 2'd2;

endpackage

// ===== design/psd_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: query point and segment endpoints, valid/ready handshake.
// No dependencies.
interface psd_in_if #(
    parameter int W = 24
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic signed [W-1:0] end_x;
    logic signed [W-1:0] end_y;

    modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                    input ready);
    modport sink   (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                    output ready);
endinterface

// ===== design/psd_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: distance, clamped parameter and zero-length flag.
// Depends on psd_pkg for the parameter width.
interface psd_out_if #(
    parameter int W = 24
);
    logic                          valid;
    logic                          ready;
    logic [W:0]                    distance;
    logic [psd_pkg::POS_BITS-1:0]  position;
    logic                          degenerate;

    modport source (output valid, distance, position, degenerate, input ready);
    modport sink   (input valid, distance, position, degenerate, output ready);
endinterface

// ===== design/point_segment_distance.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle, except while the output queue is full; the depth is set by
// the 17-stage divider and the (COORD_BITS + 2)-stage square root, each resolving one bit per
// register stage.
// A two-entry output queue lets the pipeline keep moving while a result beat waits.
// Reset (synchronous, active low) empties the pipeline valid bits and the output queue.
module point_segment_distance #(
    parameter int COORD_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    psd_in_if.sink            i_in,
    psd_out_if.source         o_out
);

    // Widths. Differences gain a bit, products double, residuals keep a rounding bit.
    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;              // B - A, P - A, and the distance
    localparam int PW   = 2 * DW;              // component products
    localparam int LW   = 2 * DW;              // squared length, unsigned
    localparam int SW   = 2 * DW + 1;          // dot product, signed
    localparam int MW   = DW + psd_pkg::QBITS + 2; // residual before rounding
    localparam int RW   = DW + 1;              // rounded residual component
    localparam int D2W  = 2 * RW;              // squared distance
    localparam int QW   = RW + 2;              // square root remainder
    localparam int NDIV = psd_pkg::NDIV;
    localparam int PB   = psd_pkg::POS_BITS;
    localparam logic signed [MW-1:0] HALF_LSB = MW'(1) << (psd_pkg::QBITS - 1);

    typedef struct packed {
        logic [DW-1:0] distance;
        logic [PB-1:0] position;
        logic          degenerate;
    } t_result;

    // The whole pipeline advances together; it holds only when the output queue is full.
    logic w_en;
    logic [1:0] r_cnt;
    assign w_en = (r_cnt != 2'd2);
    assign i_in.ready = w_en;

    // ---------------------------------------------------------------------------------
    // Stage 1: differences from the first endpoint.
    // ---------------------------------------------------------------------------------
    logic                 r1_vld;
    logic signed [DW-1:0] r1_dx, r1_dy, r1_vx, r1_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx <= DW'(i_in.end_x)   - DW'(i_in.start_x);
            r1_dy <= DW'(i_in.end_y)   - DW'(i_in.start_y);
            r1_vx <= DW'(i_in.point_x) - DW'(i_in.start_x);
            r1_vy <= DW'(i_in.point_y) - DW'(i_in.start_y);
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 2: the four component products, one multiplier each.
    // ---------------------------------------------------------------------------------
    logic                 r2_vld;
    logic signed [PW-1:0] r2_dxx, r2_dyy, r2_vxd, r2_vyd;
    logic signed [DW-1:0] r2_dx, r2_dy, r2_vx, r2_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_dxx <= r1_dx * r1_dx;
            r2_dyy <= r1_dy * r1_dy;
            r2_vxd <= r1_vx * r1_dx;
            r2_vyd <= r1_vy * r1_dy;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_vx  <= r1_vx;
            r2_vy  <= r1_vy;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 3: squared length and dot product.
    // ---------------------------------------------------------------------------------
    logic                 r3_vld;
    logic [LW-1:0]        r3_len;
    logic signed [SW-1:0] r3_s;
    logic signed [DW-1:0] r3_dx, r3_dy, r3_vx, r3_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_len <= LW'($unsigned(r2_dxx + r2_dyy));
            r3_s   <= SW'(r2_vxd) + SW'(r2_vyd);
            r3_dx  <= r2_dx;
            r3_dy  <= r2_dy;
            r3_vx  <= r2_vx;
            r3_vy  <= r2_vy;
        end
    end

    // ---------------------------------------------------------------------------------
    // Divider entry: decide whether the parameter clamps, else start S / L.
    // A zero-length segment takes the clamp-to-start path, which leaves the residual
    // equal to P - A.
    // ---------------------------------------------------------------------------------
    logic                 r_dv_vld [0:NDIV];
    logic [LW:0]          r_dv_rem [0:NDIV];
    logic [NDIV-1:0]      r_dv_q   [0:NDIV];
    logic [LW-1:0]        r_dv_len [0:NDIV];
    logic [1:0]           r_dv_mode[0:NDIV];
    logic                 r_dv_dg  [0:NDIV];
    logic signed [DW-1:0] r_dv_dx  [0:NDIV];
    logic signed [DW-1:0] r_dv_dy  [0:NDIV];
    logic signed [DW-1:0] r_dv_vx  [0:NDIV];
    logic signed [DW-1:0] r_dv_vy  [0:NDIV];

    logic       w_degen, w_s_nonpos;
    logic [1:0] w_mode;

    always_comb begin
        w_degen    = (r3_len == '0);
        w_s_nonpos = r3_s[SW-1] || (r3_s == '0);
        if (w_degen || w_s_nonpos) begin
            w_mode = psd_pkg::MODE_ZERO;
        end else if (r3_s[LW-1:0] >= r3_len) begin
            w_mode = psd_pkg::MODE_ONE;
        end else begin
            w_mode = psd_pkg::MODE_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_rem[0]  <= (LW+1)'(r3_s[LW-1:0]);
            r_dv_q[0]    <= '0;
            r_dv_len[0]  <= r3_len;
            r_dv_mode[0] <= w_mode;
            r_dv_dg[0]   <= w_degen;
            r_dv_dx[0]   <= r3_dx;
            r_dv_dy[0]   <= r3_dy;
            r_dv_vx[0]   <= r3_vx;
            r_dv_vy[0]   <= r3_vy;
        end
    end

    // Restoring division, one quotient bit per stage. The remainder stays below L.
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        logic [LW:0] w_sh;
        logic        w_ge;

        assign w_sh = {r_dv_rem[k][LW-1:0], 1'b0};
        assign w_ge = (w_sh >= {1'b0, r_dv_len[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[k+1]  <= w_ge ? (w_sh - {1'b0, r_dv_len[k]}) : w_sh;
                r_dv_q[k+1]    <= {r_dv_q[k][NDIV-2:0], w_ge};
                r_dv_len[k+1]  <= r_dv_len[k];
                r_dv_mode[k+1] <= r_dv_mode[k];
                r_dv_dg[k+1]   <= r_dv_dg[k];
                r_dv_dx[k+1]   <= r_dv_dx[k];
                r_dv_dy[k+1]   <= r_dv_dy[k];
                r_dv_vx[k+1]   <= r_dv_vx[k];
                r_dv_vy[k+1]   <= r_dv_vy[k];
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Parameter stage: clamp or round the quotient half up to Q0.16.
    // ---------------------------------------------------------------------------------
    logic                 r_t_vld;
    logic [PB-1:0]        r_t_t;
    logic                 r_t_dg;
    logic signed [DW-1:0] r_t_dx, r_t_dy, r_t_vx, r_t_vy;
    logic [PB-1:0]        w_t;
    logic [NDIV:0]        w_q_inc;

    always_comb begin
        w_q_inc = (NDIV+1)'(r_dv_q[NDIV]) + (NDIV+1)'(1);
        unique case (r_dv_mode[NDIV])
            psd_pkg::MODE_ZERO: w_t = '0;
            psd_pkg::MODE_ONE:  w_t = psd_pkg::POS_ONE;
            psd_pkg::MODE_DIV:  w_t = w_q_inc[NDIV:1];
            default:            w_t = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (w_en) begin
            r_t_vld <= r_dv_vld[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_t  <= w_t;
            r_t_dg <= r_dv_dg[NDIV];
            r_t_dx <= r_dv_dx[NDIV];
            r_t_dy <= r_dv_dy[NDIV];
            r_t_vx <= r_dv_vx[NDIV];
            r_t_vy <= r_dv_vy[NDIV];
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage M: the nearest point's offset along the segment, D * t.
    // ---------------------------------------------------------------------------------
    logic                 r_m_vld;
    logic signed [MW-1:0] r_m_px, r_m_py;
    logic [PB-1:0]        r_m_t;
    logic                 r_m_dg;
    logic signed [DW-1:0] r_m_vx, r_m_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= r_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_px <= r_t_dx * $signed({1'b0, r_t_t});
            r_m_py <= r_t_dy * $signed({1'b0, r_t_t});
            r_m_t  <= r_t_t;
            r_m_dg <= r_t_dg;
            r_m_vx <= r_t_vx;
            r_m_vy <= r_t_vy;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage R: residual V - D * t, rounded half up back to the coordinate format.
    // ---------------------------------------------------------------------------------
    logic                 r_r_vld;
    logic signed [RW-1:0] r_r_rx, r_r_ry;
    logic [PB-1:0]        r_r_t;
    logic                 r_r_dg;
    logic signed [MW-1:0] w_res_x, w_res_y;

    assign w_res_x = MW'($signed({r_m_vx, {psd_pkg::QBITS{1'b0}}})) - r_m_px + HALF_LSB;
    assign w_res_y = MW'($signed({r_m_vy, {psd_pkg::QBITS{1'b0}}})) - r_m_py + HALF_LSB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
        end else if (w_en) begin
            r_r_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r_rx <= w_res_x[psd_pkg::QBITS +: RW];
            r_r_ry <= w_res_y[psd_pkg::QBITS +: RW];
            r_r_t  <= r_m_t;
            r_r_dg <= r_m_dg;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage Q: squares of the residual components.
    // ---------------------------------------------------------------------------------
    logic                  r_q_vld;
    logic signed [D2W-1:0] r_q_xx, r_q_yy;
    logic [PB-1:0]         r_q_t;
    logic                  r_q_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else if (w_en) begin
            r_q_vld <= r_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q_xx <= r_r_rx * r_r_rx;
            r_q_yy <= r_r_ry * r_r_ry;
            r_q_t  <= r_r_t;
            r_q_dg <= r_r_dg;
        end
    end

    // ---------------------------------------------------------------------------------
    // Square root: the squared distance enters, then one root bit per stage.
    // ---------------------------------------------------------------------------------
    logic           r_sq_vld [0:RW];
    logic [D2W-1:0] r_sq_d2  [0:RW];
    logic [RW-1:0]  r_sq_root[0:RW];
    logic [QW-1:0]  r_sq_rem [0:RW];
    logic [PB-1:0]  r_sq_t   [0:RW];
    logic           r_sq_dg  [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_vld[0] <= r_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_d2[0]   <= $unsigned(r_q_xx) + $unsigned(r_q_yy);
            r_sq_root[0] <= '0;
            r_sq_rem[0]  <= '0;
            r_sq_t[0]    <= r_q_t;
            r_sq_dg[0]   <= r_q_dg;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [QW-1:0] w_cur;
        logic [QW-1:0] w_trial;
        logic          w_ge;

        assign w_cur   = {r_sq_rem[k][QW-3:0], r_sq_d2[k][2*(RW-1-k) +: 2]};
        assign w_trial = {r_sq_root[k], 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[k+1]  <= w_ge ? (w_cur - w_trial) : w_cur;
                r_sq_root[k+1] <= {r_sq_root[k][RW-2:0], w_ge};
                r_sq_d2[k+1]   <= r_sq_d2[k];
                r_sq_t[k+1]    <= r_sq_t[k];
                r_sq_dg[k+1]   <= r_sq_dg[k];
            end
        end
    end

    // Round to nearest: the remainder is d2 - root^2, so round up once it passes root.
    logic [RW:0] w_root_rnd;
    t_result     w_res;

    always_comb begin
        w_root_rnd = (RW+1)'(r_sq_root[RW])
                   + (RW+1)'(r_sq_rem[RW] > QW'(r_sq_root[RW]));
        w_res.distance   = w_root_rnd[DW-1:0];
        w_res.position   = r_sq_t[RW];
        w_res.degenerate = r_sq_dg[RW];
    end

    // ---------------------------------------------------------------------------------
    // Output queue: two entries, so a waiting result beat does not stop intake.
    // ---------------------------------------------------------------------------------
    t_result r_buf [0:1];
    logic    r_wp, r_rp;
    logic    w_push, w_pop;

    assign w_push = w_en && r_sq_vld[RW];
    assign w_pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_res;
        end
    end

    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.distance   = r_buf[r_rp].distance;
    assign o_out.position   = r_buf[r_rp].position;
    assign o_out.degenerate = r_buf[r_rp].degenerate;

    // ---------------------------------------------------------------------------------
    // Checks.
    // ---------------------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_div_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[0] && (r_dv_mode[0] == psd_pkg::MODE_DIV) |-> r_dv_rem[0] < r_dv_len[0])
        else $error("division entered with dividend not below divisor");

    a_degen_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.degenerate |-> o_out.position == '0)
        else $error("zero-length segment with nonzero parameter");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.position <= psd_pkg::POS_ONE)
        else $error("parameter above segment end");

endmodule

// ===== bench/point_segment_distance_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the point to segment distance pipeline.
// Depends on psd_pkg, psd_in_if and psd_out_if, and on the block itself.

module point_segment_distance_test;

    localparam int CW = 24;

    // One expected result beat.
    typedef struct {
        logic [CW:0]                  distance;
        logic [psd_pkg::POS_BITS-1:0] position;
        logic                         degenerate;
    } t_dist_result;

    // The scoreboard works out the distance for each query that enters and
    // holds the answers in order until the block delivers them.
    class distance_scoreboard;
        t_dist_result pending[$];
        int           errors;
        int           checked;

        // Rounds a value with 16 extra fraction bits, halves up.
        function automatic longint drop_q16(longint r);
            return (r + 64'sd32768) >>> 16;
        endfunction

        function automatic longint unsigned root_round(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv >>= 2;
            end
            if (v > res) res = res + 1;
            return res;
        endfunction

        function void note_query(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                 logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                 logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
            longint dx, dy, vx, vy, s, rx, ry;
            longint unsigned len2, q, rem, t;
            t_dist_result res;
            dx   = longint'(bx) - longint'(ax);
            dy   = longint'(by) - longint'(ay);
            vx   = longint'(px) - longint'(ax);
            vy   = longint'(py) - longint'(ay);
            len2 = dx * dx + dy * dy;
            t    = 0;
            res.degenerate = (len2 == 0);
            if (res.degenerate) begin
                rx = vx;
                ry = vy;
            end else begin
                s = vx * dx + vy * dy;
                if (s <= 0) begin
                    t = 0;
                end else if (longint'(len2) <= s) begin
                    t = psd_pkg::POS_ONE;
                end else begin
                    // Long division, one quotient bit beyond Q0.16, then round.
                    rem = s;
                    q   = 0;
                    for (int i = 0; i < psd_pkg::NDIV; i++) begin
                        rem = rem << 1;
                        q   = q << 1;
                        if (rem >= len2) begin
                            rem = rem - len2;
                            q   = q | 1;
                        end
                    end
                    t = (q + 1) >> 1;
                end
                rx = drop_q16(vx * 65536 - dx * longint'(t));
                ry = drop_q16(vy * 65536 - dy * longint'(t));
            end
            res.distance = (CW+1)'(root_round(rx * rx + ry * ry));
            res.position = t[psd_pkg::POS_BITS-1:0];
            pending = {pending, res};
        endfunction

        function void check_result(logic [CW:0] distance,
                                   logic [psd_pkg::POS_BITS-1:0] position,
                                   logic degenerate);
            t_dist_result exp;
            if (pending.size() == 0) begin
                $error("result beat arrived with nothing expected");
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (distance !== exp.distance) begin
                $error("distance: expected %0d, got %0d", exp.distance, distance);
                errors++;
            end
            if (position !== exp.position) begin
                $error("position: expected %0d, got %0d", exp.position, position);
                errors++;
            end
            if (degenerate !== exp.degenerate) begin
                $error("degenerate: expected %0d, got %0d", exp.degenerate, degenerate);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    psd_in_if  #(.W(CW)) query_ch ();
    psd_out_if #(.W(CW)) answer_ch ();

    point_segment_distance #(.COORD_BITS(CW)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (query_ch.sink),
        .o_out  (answer_ch.source)
    );

    distance_scoreboard board;
    int  cycle_count;
    bit  sending_done;
    bit  hold_answers;
    int  sent_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Known values on every input before the first edge.
    initial begin
        board             = new();
        i_rst_n           = 1'b0;
        query_ch.valid    = 1'b0;
        query_ch.point_x  = '0;
        query_ch.point_y  = '0;
        query_ch.start_x  = '0;
        query_ch.start_y  = '0;
        query_ch.end_x    = '0;
        query_ch.end_y    = '0;
        answer_ch.ready   = 1'b0;
    end

    // Mostly short gaps, now and then a long one, and often none at all.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Coordinate generator: extremes, small values near zero, or anything.
    function automatic logic signed [CW-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(CW-1){1'b0}}};
            1: return {1'b0, {(CW-1){1'b1}}};
            2, 3: return CW'($signed($urandom_range(0, 2047)) - 1024);
            default: return CW'($urandom);
        endcase
    endfunction

    // Offers one beat, holds it until accepted, and records it on acceptance.
    task automatic send_query(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                              logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                              logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            query_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        query_ch.valid   <= 1'b1;
        query_ch.point_x <= px;
        query_ch.point_y <= py;
        query_ch.start_x <= ax;
        query_ch.start_y <= ay;
        query_ch.end_x   <= bx;
        query_ch.end_y   <= by;
        do @(posedge i_clk); while (!query_ch.ready);
        board.note_query(px, py, ax, ay, bx, by);
        sent_count++;
    endtask

    // Stimulus: a directed opening, then random queries.
    initial begin
        logic signed [CW-1:0] mx, mn, ax, ay, bx, by;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero-length segments, including at the corners of the range.
        send_query(24'sd300, -24'sd200, 24'sd5, 24'sd5, 24'sd5, 24'sd5);
        send_query(mx, mx, mn, mn, mn, mn);
        send_query(mn, mx, mx, mn, mx, mn);
        send_query(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
        // Projection before the start, beyond the end, and strictly inside.
        send_query(-24'sd512, 24'sd0, 24'sd0, 24'sd0, 24'sd256, 24'sd0);
        send_query(24'sd1024, 24'sd77, 24'sd0, 24'sd0, 24'sd256, 24'sd0);
        send_query(24'sd100, 24'sd900, 24'sd0, 24'sd0, 24'sd256, 24'sd0);
        // Exactly on the end point and on the start point.
        send_query(24'sd256, 24'sd256, 24'sd0, 24'sd0, 24'sd256, 24'sd256);
        send_query(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd256, 24'sd256);
        // Longest segments and farthest points.
        send_query(mx, mn, mn, mn, mx, mx);
        send_query(mn, mx, mx, mn, mx, mn + 24'sd1);
        send_query(mn, mn, mx, mx, mx - 24'sd1, mx);
        send_query(24'sd0, mx, mn, 24'sd0, mx, 24'sd0);
        send_query(mn, mn, mx, mx, mn, mx);
        // Shortest non-degenerate segments, where rounding matters most.
        send_query(24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd3, 24'sd1);
        send_query(mx, mx, 24'sd0, 24'sd0, 24'sd1, 24'sd0);
        send_query(24'sd2, 24'sd1, 24'sd0, 24'sd0, 24'sd3, 24'sd3);

        for (int n = 0; n < 600; n++) begin
            ax = pick_coord();
            ay = pick_coord();
            if ($urandom_range(0, 19) == 0) begin
                bx = ax;
                by = ay;
            end else if ($urandom_range(0, 3) == 0) begin
                // Short segments give fine fractions of the parameter.
                bx = ax + CW'($signed($urandom_range(0, 63)) - 32);
                by = ay + CW'($signed($urandom_range(0, 63)) - 32);
            end else begin
                bx = pick_coord();
                by = pick_coord();
            end
            send_query(pick_coord(), pick_coord(), ax, ay, bx, by);
        end
        query_ch.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // A long hold-off on the result side once traffic is under way, so that
    // the pipeline and its small output queue fill and push back on the input.
    initial begin
        hold_answers = 1'b0;
        wait (sent_count >= 120);
        hold_answers = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_answers = 1'b0;
    end

    // Result side: random stalls, and checks of each accepted beat.
    always @(posedge i_clk) begin
        if (i_rst_n && answer_ch.valid && answer_ch.ready) begin
            board.check_result(answer_ch.distance, answer_ch.position,
                               answer_ch.degenerate);
        end
        if (hold_answers) begin
            answer_ch.ready <= 1'b0;
        end else begin
            answer_ch.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0);
        end
    end

    // End of run and a watchdog on the cycle count.
    initial begin
        cycle_count = 0;
        fork
            begin
                wait (sending_done);
                while (board.pending.size() != 0) @(posedge i_clk);
                repeat (120) @(posedge i_clk);
                $display("Checked %0d result beats against %0d query beats,",
                         board.checked, sent_count);
                $display("covering zero-length, clamped and interior segments.");
                if (board.errors == 0 && board.pending.size() == 0) begin
                    $display("All tests passed");
                end else begin
                    $display("Some tests failed");
                end
                $finish;
            end
            begin
                forever begin
                    @(posedge i_clk);
                    cycle_count++;
                    if (cycle_count > 200000) begin
                        $display("Timed out after %0d cycles.", cycle_count);
                        $display("Some tests failed");
                        $finish;
                    end
                end
            end
        join
    end

endmodule
